// ----- design/atclr_pkg.sv -----
`timescale 1ns / 1ps

package atclr_pkg;

	localparam int NUM_KEYS = 12;
	localparam int KEY_COLS = 16;

	// Command codes
	localparam logic [3:0] CODE_NONE     = 4'd0;
	localparam logic [3:0] CODE_ESCAPE   = 4'd1;
	localparam logic [3:0] CODE_ATI      = 4'd2;
	localparam logic [3:0] CODE_ATO      = 4'd3;
	localparam logic [3:0] CODE_CGATT    = 4'd4;
	localparam logic [3:0] CODE_CIICR    = 4'd5;
	localparam logic [3:0] CODE_CIPSTART = 4'd6;
	localparam logic [3:0] CODE_CIPCLOSE = 4'd7;
	localparam logic [3:0] CODE_DIAL     = 4'd8;
	localparam logic [3:0] CODE_ATH      = 4'd9;
	localparam logic [3:0] CODE_ATC      = 4'd10;
	localparam logic [3:0] CODE_AT       = 4'd11;
	localparam logic [3:0] CODE_RST      = 4'd12;

	// Result kinds
	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_EOL   = 1'b1;

	// Special characters
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_COMMA   = 8'd44;
	localparam logic [7:0] NUL          = 8'h00;

	localparam logic [3:0] POS_MAX = 4'd15;

	// Keyword text, padded with NUL; row k holds keyword of code k+1
	localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_COLS] = '{
		'{"+", "+", "+", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "I", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "O", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "+", "C", "G", "A", "T", "T", "?", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "+", "C", "I", "I", "C", "R", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "+", "C", "I", "P", "S", "T", "A", "R", "T", "=", NUL, NUL, NUL, NUL},
		'{"A", "T", "+", "C", "I", "P", "C", "L", "O", "S", "E", NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "D", "+", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "H", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "C", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL},
		'{"A", "T", "+", "R", "S", "T", NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL, NUL}
	};

	localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
		4'd3, 4'd3, 4'd3, 4'd9, 4'd8, 4'd12, 4'd11, 4'd4, 4'd3, 4'd3, 4'd2, 4'd6
	};

	// Bit k set for keywords that match as a prefix
	localparam logic [NUM_KEYS-1:0] KEY_IS_PREFIX = 12'b0000_1010_0000;

	typedef struct packed {
		logic       result_kind;
		logic [3:0] command_code;
		logic       param_index;
		logic [7:0] param_byte;
	} res_t;

endpackage

// ----- design/atclr_match.sv -----
`timescale 1ns / 1ps

module atclr_match (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          rx_byte,
	output logic                res_valid,
	output atclr_pkg::res_t     res
);

	localparam logic [1:0] MODE_KEY = 2'd0;
	localparam logic [1:0] MODE_P1  = 2'd1;
	localparam logic [1:0] MODE_P2  = 2'd2;

	logic [3:0]                     pos_q, pos_d;
	logic [atclr_pkg::NUM_KEYS-1:0] cand_q, cand_d, cand_next;
	logic [1:0]                     mode_q, mode_d;
	logic [3:0]                     pend_q, pend_d;
	logic [3:0]                     eol_code;
	logic [3:0]                     pos_next;

	// Per-keyword character compare, and exact-match lookup for end of line
	always_comb begin
		eol_code = atclr_pkg::CODE_NONE;
		for (int k = 0; k < atclr_pkg::NUM_KEYS; k++) begin
			cand_next[k] = cand_q[k] && (pos_q < atclr_pkg::KEY_LEN[k]) &&
				(atclr_pkg::KEY_TEXT[k][pos_q] == rx_byte);
		end
		// descending so the lowest code wins
		for (int k = atclr_pkg::NUM_KEYS - 1; k >= 0; k--) begin
			if (cand_q[k] && !atclr_pkg::KEY_IS_PREFIX[k] &&
				atclr_pkg::KEY_LEN[k] == pos_q) begin
				eol_code = 4'(k + 1);
			end
		end
	end

	assign pos_next = (pos_q == atclr_pkg::POS_MAX) ? pos_q : pos_q + 4'd1;

	// Next state and result for one item
	always_comb begin
		pos_d     = pos_q;
		cand_d    = cand_q;
		mode_d    = mode_q;
		pend_d    = pend_q;
		res_valid = 1'b0;
		res       = '0;
		if (rx_byte == atclr_pkg::CHAR_NEWLINE) begin
			pos_d  = '0;
			cand_d = '1;
			mode_d = MODE_KEY;
			pend_d = atclr_pkg::CODE_NONE;
			if (mode_q != MODE_KEY || pos_q != 4'd0) begin
				res_valid        = 1'b1;
				res.result_kind  = atclr_pkg::KIND_EOL;
				res.command_code = (mode_q != MODE_KEY) ? pend_q : eol_code;
			end
		end else if (mode_q != MODE_KEY) begin
			if (mode_q == MODE_P1 && pend_q == atclr_pkg::CODE_CIPSTART &&
				rx_byte == atclr_pkg::CHAR_COMMA) begin
				mode_d = MODE_P2;
			end else begin
				res_valid        = 1'b1;
				res.result_kind  = atclr_pkg::KIND_PARAM;
				res.command_code = pend_q;
				res.param_index  = (mode_q != MODE_P1);
				res.param_byte   = rx_byte;
			end
		end else begin
			cand_d = cand_next;
			pos_d  = pos_next;
			// prefix keywords complete: enter parameter streaming
			if (cand_next[atclr_pkg::CODE_CIPSTART - 4'd1] &&
				pos_next == atclr_pkg::KEY_LEN[atclr_pkg::CODE_CIPSTART - 4'd1]) begin
				mode_d = MODE_P1;
				pend_d = atclr_pkg::CODE_CIPSTART;
			end else if (cand_next[atclr_pkg::CODE_DIAL - 4'd1] &&
				pos_next == atclr_pkg::KEY_LEN[atclr_pkg::CODE_DIAL - 4'd1]) begin
				mode_d = MODE_P1;
				pend_d = atclr_pkg::CODE_DIAL;
			end
		end
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cand_q <= '1;
			mode_q <= MODE_KEY;
			pend_q <= atclr_pkg::CODE_NONE;
		end else if (step_en) begin
			pos_q  <= pos_d;
			cand_q <= cand_d;
			mode_q <= mode_d;
			pend_q <= pend_d;
		end
	end

`ifndef SYNTH
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("parameter mode reached unused value");

	a_pend_key: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_KEY |-> pend_q == atclr_pkg::CODE_NONE)
		else $error("pending command set while matching keywords");

	a_pend_param: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_KEY |->
			(pend_q == atclr_pkg::CODE_CIPSTART || pend_q == atclr_pkg::CODE_DIAL))
		else $error("parameter mode without prefix command");

	a_p2_cipstart: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_P2 |-> pend_q == atclr_pkg::CODE_CIPSTART)
		else $error("second parameter outside CIPSTART");
`endif

endmodule

// ----- design/atclr_out.sv -----
`timescale 1ns / 1ps

module atclr_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  atclr_pkg::res_t res,
	input  logic            out_stall,
	output logic            take,
	output logic            out_valid,
	output logic            result_kind,
	output logic [3:0]      command_code,
	output logic            param_index,
	output logic [7:0]      param_byte
);

	logic            valid_q;
	atclr_pkg::res_t res_q;

	// register can take a new item when empty or being drained
	assign take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take && load) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign result_kind  = res_q.result_kind;
	assign command_code = res_q.command_code;
	assign param_index  = res_q.param_index;
	assign param_byte   = res_q.param_byte;

endmodule

// ----- design/at_command_line_recognizer_unit.sv -----
`timescale 1ns / 1ps
// An accepted byte sits in the input register, then its result loads into the result
// register; bytes that cause no result leave nothing.
// Throughput: one byte per cycle while out_stall does not hold the result register.
// Reset: arst_n clears the line state to start of line and empties both registers.
module at_command_line_recognizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [3:0] command_code,
	output logic       param_index,
	output logic [7:0] param_byte
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            take;
	logic            step_en;
	logic            res_valid;
	atclr_pkg::res_t res;

	// input register advances whenever the result register can take an item
	assign step_en  = valid_s1 && take;
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	atclr_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	atclr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step_en && res_valid),
		.res          (res),
		.out_stall    (out_stall),
		.take         (take),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.command_code (command_code),
		.param_index  (param_index),
		.param_byte   (param_byte)
	);

endmodule

// ----- tb/sv/at_command_line_recognizer_unit_test.sv -----
`timescale 1ns / 1ps

module at_command_line_recognizer_unit_test;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 500000;

	// Where the line is: still matching keywords, or streaming parameters
	localparam logic [1:0] MODE_KEYWORD = 2'd0;
	localparam logic [1:0] MODE_FIRST   = 2'd1;
	localparam logic [1:0] MODE_SECOND  = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0D;

	typedef struct {
		logic [7:0]      ch;
		bit              typed;
		bit              has_res;
		atclr_pkg::res_t res;
	} stim_row_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       result_kind;
	logic [3:0] command_code;
	logic       param_index;
	logic [7:0] param_byte;

	// Line recognizer state as predicted
	logic [3:0]                     line_pos;
	logic [atclr_pkg::NUM_KEYS-1:0] live_keys;
	logic [1:0]                     param_state;
	logic [3:0]                     open_cmd;

	atclr_pkg::res_t line_results_q[$];
	stim_row_t       dir_rows[$];
	logic [7:0]      line_q[$];
	atclr_pkg::res_t next_result;
	int              bytes_sent  = 0;
	int              mismatches  = 0;
	int              burst_left  = 0;
	int              cycle_cnt   = 0;
	bit              paused_once = 0;

	at_command_line_recognizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.command_code (command_code),
		.param_index  (param_index),
		.param_byte   (param_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Back to start of line
	function automatic void clear_line();
		line_pos    = 4'd0;
		live_keys   = '1;
		param_state = MODE_KEYWORD;
		open_cmd    = atclr_pkg::CODE_NONE;
	endfunction

	// Append one character to the line under construction
	function automatic void line_add(input logic [7:0] c);
		line_q = {line_q, c};
	endfunction

	// Append one expected result
	function automatic void expect_add(input atclr_pkg::res_t r);
		line_results_q = {line_results_q, r};
	endfunction

	// Predict what one received byte produces; returns 1 when there is a result
	function automatic bit parse_byte(input logic [7:0] b, output atclr_pkg::res_t r);
		bit hit;
		r = '0;
		hit = 0;
		if (b == atclr_pkg::CHAR_NEWLINE) begin
			if (param_state == MODE_KEYWORD && line_pos == 4'd0)
				return 0;
			r.result_kind = atclr_pkg::KIND_EOL;
			if (param_state != MODE_KEYWORD) begin
				r.command_code = open_cmd;
			end else begin
				for (int k = 0; k < atclr_pkg::NUM_KEYS; k++)
					if (!hit && live_keys[k] && !atclr_pkg::KEY_IS_PREFIX[k] &&
						atclr_pkg::KEY_LEN[k] == line_pos) begin
						r.command_code = 4'(k + 1);
						hit = 1;
					end
			end
			clear_line();
			return 1;
		end
		// Parameter streaming; the first comma of CIPSTART splits address from port
		if (param_state != MODE_KEYWORD) begin
			if (param_state == MODE_FIRST && open_cmd == atclr_pkg::CODE_CIPSTART &&
				b == atclr_pkg::CHAR_COMMA) begin
				param_state = MODE_SECOND;
				return 0;
			end
			r.result_kind  = atclr_pkg::KIND_PARAM;
			r.command_code = open_cmd;
			r.param_index  = (param_state == MODE_FIRST) ? 1'b0 : 1'b1;
			r.param_byte   = b;
			return 1;
		end
		// Keyword matching: drop every candidate that no longer fits
		for (int k = 0; k < atclr_pkg::NUM_KEYS; k++)
			if (live_keys[k] && (line_pos >= atclr_pkg::KEY_LEN[k] ||
				atclr_pkg::KEY_TEXT[k][line_pos] != b))
				live_keys[k] = 1'b0;
		if (line_pos < atclr_pkg::POS_MAX)
			line_pos = line_pos + 4'd1;
		// A complete prefix switches to parameters
		for (int k = 0; k < atclr_pkg::NUM_KEYS; k++)
			if (!hit && live_keys[k] && atclr_pkg::KEY_IS_PREFIX[k] &&
				atclr_pkg::KEY_LEN[k] == line_pos) begin
				param_state = MODE_FIRST;
				open_cmd    = 4'(k + 1);
				hit = 1;
			end
		return 0;
	endfunction

	// Random printable-or-not character, never a newline
	function automatic logic [7:0] text_byte(input bit no_comma);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == atclr_pkg::CHAR_NEWLINE || (no_comma && c == atclr_pkg::CHAR_COMMA));
		if (!no_comma && $urandom_range(0, 6) == 0)
			c = atclr_pkg::CHAR_COMMA;
		return c;
	endfunction

	task automatic add_text(input string s);
		stim_row_t row;
		for (int i = 0; i < s.len(); i++) begin
			row = '{ch: s[i], typed: 0, has_res: 0, res: '0};
			dir_rows = {dir_rows, row};
		end
	endtask

	task automatic add_checked(input logic [7:0] ch, input bit has_res, input logic kind,
			input logic [3:0] code, input logic [7:0] pb);
		stim_row_t row;
		row.ch      = ch;
		row.typed   = 1;
		row.has_res = has_res;
		row.res     = '{result_kind: kind, command_code: code, param_index: 1'b0,
			param_byte: pb};
		dir_rows = {dir_rows, row};
	endtask

	// Offer one item, wait for it to be taken, record its result, then maybe go idle
	task automatic drive_byte(input logic [7:0] b, input bit typed, input bit has_res,
			input atclr_pkg::res_t typed_res);
		atclr_pkg::res_t pr;
		bit              got;
		int              gap;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		got = parse_byte(b, pr);
		if (typed) begin
			if (has_res)
				expect_add(typed_res);
		end else if (got) begin
			expect_add(pr);
		end
		// Bursts of random length, gaps between them
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
				$urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending until all predicted results are out
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (line_results_q.size() != 0);
	endtask

	// One random line: mostly keywords, prefix ones with random parameters, some damaged lines and noise
	task automatic build_line();
		int pick;
		int k;
		int n;
		int cut;
		line_q.delete();
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, atclr_pkg::NUM_KEYS - 1);
		if (pick < 60) begin
			for (int i = 0; i < atclr_pkg::KEY_LEN[k]; i++)
				line_add(atclr_pkg::KEY_TEXT[k][i]);
			if (atclr_pkg::KEY_IS_PREFIX[k]) begin
				n = $urandom_range(0, 8);
				repeat (n) line_add(text_byte(k == atclr_pkg::CODE_CIPSTART - 1));
				if (k == atclr_pkg::CODE_CIPSTART - 1 && $urandom_range(0, 4) != 0) begin
					line_add(atclr_pkg::CHAR_COMMA);
					n = $urandom_range(0, 6);
					repeat (n) line_add(text_byte(0));
				end
			end else begin
				case ($urandom_range(0, 19))
					0: line_add(text_byte(0));
					1: void'(line_q.pop_back());
					2: line_q[$urandom_range(0, line_q.size() - 1)] = text_byte(0);
					3: line_add(CHAR_CR);
					default: ;
				endcase
			end
		end else if (pick < 75) begin
			cut = $urandom_range(1, atclr_pkg::KEY_LEN[k]);
			for (int i = 0; i < cut; i++)
				line_add(atclr_pkg::KEY_TEXT[k][i]);
			line_q[$urandom_range(0, cut - 1)] = text_byte(0);
		end else if (pick < 83) begin
			// empty line
		end else if (pick < 95) begin
			n = $urandom_range(1, 6);
			repeat (n) line_add(8'($urandom_range(0, 255)));
		end else begin
			// long line, mostly past where the position saturates
			line_add("A");
			line_add("T");
			n = $urandom_range(12, 22);
			repeat (n) line_add(text_byte(0));
		end
		line_add(atclr_pkg::CHAR_NEWLINE);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (line_results_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got kind %0d code %0d idx %0d byte %0d",
					$time, result_kind, command_code, param_index, param_byte);
			end else begin
				next_result = line_results_q.pop_front();
				check_field("result_kind", next_result.result_kind, result_kind);
				check_field("command_code", next_result.command_code, command_code);
				check_field("param_index", next_result.param_index, param_index);
				check_field("param_byte", next_result.param_byte, param_byte);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: stretches of differing stall density, one long hold-off
	initial begin
		int pct;
		int stretch;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			case ($urandom_range(0, 4))
				0, 1: pct = 0;
				2: pct = 20;
				3: pct = 50;
				default: pct = 85;
			endcase
			stretch = $urandom_range(5, 60);
			repeat (stretch) begin
				@(posedge clk);
				if (!held && bytes_sent >= 600) begin
					held = 1;
					out_stall <= 1'b1;
					repeat (120) @(posedge clk);
				end
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// Stimulus
	initial begin
		// Directed lines
		add_checked(atclr_pkg::CHAR_NEWLINE, 0, atclr_pkg::KIND_EOL, atclr_pkg::CODE_NONE,
			atclr_pkg::NUL);
		add_text("AT");
		add_checked(atclr_pkg::CHAR_NEWLINE, 1, atclr_pkg::KIND_EOL, atclr_pkg::CODE_AT,
			atclr_pkg::NUL);
		add_text("ATD+");
		add_checked(8'hFF, 1, atclr_pkg::KIND_PARAM, atclr_pkg::CODE_DIAL, 8'hFF);
		add_checked(atclr_pkg::NUL, 1, atclr_pkg::KIND_PARAM, atclr_pkg::CODE_DIAL,
			atclr_pkg::NUL);
		add_checked(atclr_pkg::CHAR_COMMA, 1, atclr_pkg::KIND_PARAM, atclr_pkg::CODE_DIAL,
			atclr_pkg::CHAR_COMMA);
		add_checked(atclr_pkg::CHAR_NEWLINE, 1, atclr_pkg::KIND_EOL, atclr_pkg::CODE_DIAL,
			atclr_pkg::NUL);
		add_text("X");
		add_checked(atclr_pkg::CHAR_NEWLINE, 1, atclr_pkg::KIND_EOL, atclr_pkg::CODE_NONE,
			atclr_pkg::NUL);
		add_text("+++");
		add_checked(atclr_pkg::CHAR_NEWLINE, 1, atclr_pkg::KIND_EOL, atclr_pkg::CODE_ESCAPE,
			atclr_pkg::NUL);
		add_text("ATIX");
		add_checked(atclr_pkg::CHAR_NEWLINE, 1, atclr_pkg::KIND_EOL, atclr_pkg::CODE_NONE,
			atclr_pkg::NUL);

		clear_line();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			drive_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);
		drain();

		// Random lines
		while (bytes_sent < RANDOM_ITEMS + dir_rows.size()) begin
			if (!paused_once && bytes_sent >= 1200) begin
				paused_once = 1;
				drain();
			end
			build_line();
			foreach (line_q[i])
				drive_byte(line_q[i], 0, 0, '0);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
